// ----- rtl/slr_pkg.sv -----
// shared widths, limits and codes for the servo linear ramp
package slr_pkg;

  // payload widths
  localparam int KIND_W  = 1;
  localparam int CH_W    = 3;
  localparam int PULSE_W = 12;
  localparam int DUR_W   = 16;
  localparam int POSQ_W  = 28;

  // clamped move time fits here
  localparam int TIME_W  = 14;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SET  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TICK = 1'b1;

  // pulse and time limits
  localparam int PULSE_MAX      = 2490;
  localparam int PULSE_MIN_SET  = 510;
  localparam int PULSE_MIN_TICK = 500;
  localparam int PULSE_RESET    = 1500;
  localparam int TIME_MAX       = 10000;

  // parameter defaults
  localparam int CHANNELS_DEF  = 4;
  localparam int TICK_MS_DEF   = 20;
  localparam int FRAC_BITS_DEF = 16;

endpackage

// ----- rtl/slr_if.sv -----
// valid/ready channels for command/tick beats and result beats

interface slr_in_if;
  logic                         valid;
  logic                         ready;
  logic [slr_pkg::KIND_W-1:0]   kind;
  logic [slr_pkg::CH_W-1:0]     channel;
  logic [slr_pkg::PULSE_W-1:0]  target_us;
  logic [slr_pkg::DUR_W-1:0]    duration_ms;

  modport source (output valid, kind, channel, target_us, duration_ms, input ready);
  modport sink   (input valid, kind, channel, target_us, duration_ms, output ready);
endinterface

interface slr_out_if;
  logic                         valid;
  logic                         ready;
  logic [slr_pkg::CH_W-1:0]     channel_out;
  logic [slr_pkg::POSQ_W-1:0]   position_q16;
  logic [slr_pkg::PULSE_W-1:0]  position_us;
  logic                         moving;
  logic                         ignored;

  modport source (output valid, channel_out, position_q16, position_us, moving, ignored,
                  input ready);
  modport sink   (input valid, channel_out, position_q16, position_us, moving, ignored,
                  output ready);
endinterface

// ----- rtl/slr_mem.sv -----
// per-channel state memory, registered read, entries read as reset word until written
module slr_mem #(
  parameter int               DEPTH    = 4,
  parameter int               WIDTH    = 8,
  parameter int               AW       = 2,
  parameter logic [WIDTH-1:0] RST_WORD = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : RST_WORD;

endmodule

// ----- rtl/slr_div.sv -----
// unsigned restoring divider, one quotient bit per cycle
module slr_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_nx;

  always_comb begin
    rem_sh = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
    rem_nx = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        rem_r <= rem_nx;
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/servo_linear_ramp.sv -----
// servo linear ramp: per-channel pulse ramp driven by set and tick beats
// one beat in flight at a time; a result waits in the output register while the next beat enters
// set with a move: S_LOAD, S_EVAL, S_MUL, S_DIVGO, S_DIV (bit-serial divider), S_DONE; out-of-range: S_DONE
// tick with a step: S_LOAD, S_EVAL, S_TSTEP, S_DONE; tick with no step, stop or jump: S_LOAD, S_EVAL, S_DONE
// synchronous active-low reset; every channel reads 1500 us, target 1500, no increment
// until first written (per-entry valid bits, no clearing pass)
module servo_linear_ramp #(
  parameter int CHANNELS  = slr_pkg::CHANNELS_DEF,
  parameter int TICK_MS   = slr_pkg::TICK_MS_DEF,
  parameter int FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  slr_in_if.sink    in_ch,
  slr_out_if.source out_ch
);

  // state word widths
  localparam int PW      = slr_pkg::PULSE_W;
  localparam int CUR_W   = PW + FRAC_BITS;       // unsigned current pulse
  localparam int INC_W   = CUR_W + 1;            // signed increment
  localparam int TK_W    = $clog2(TICK_MS + 1);
  localparam int NUM_W   = CUR_W + TK_W;         // |distance| * tick
  localparam int TW      = slr_pkg::TIME_W;
  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = CUR_W + PW + INC_W;

  localparam logic [CUR_W-1:0]   CUR_RST  = CUR_W'(slr_pkg::PULSE_RESET) << FRAC_BITS;
  localparam logic [PW-1:0]      TGT_RST  = PW'(slr_pkg::PULSE_RESET);
  localparam logic [ENTRY_W-1:0] RST_WORD = {CUR_RST, TGT_RST, {INC_W{1'b0}}};

  localparam logic [PW-1:0] P_MAX      = PW'(slr_pkg::PULSE_MAX);
  localparam logic [PW-1:0] P_MIN_SET  = PW'(slr_pkg::PULSE_MIN_SET);
  localparam logic [PW-1:0] P_MIN_TICK = PW'(slr_pkg::PULSE_MIN_TICK);
  localparam logic [TW-1:0] T_MAX      = TW'(slr_pkg::TIME_MAX);
  localparam logic [TW-1:0] T_TICK     = TW'(TICK_MS);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_EVAL, S_MUL, S_DIVGO, S_DIV, S_TSTEP, S_DONE
  } state_t;

  state_t state_r;

  // latched beat
  logic [slr_pkg::KIND_W-1:0] kind_r;
  logic [slr_pkg::CH_W-1:0]   ch_r;
  logic [PW-1:0]              tin_r;
  logic [slr_pkg::DUR_W-1:0]  dur_r;
  logic                       ign_r;

  // working copy of the channel entry
  logic [CUR_W-1:0] cur_r;
  logic [PW-1:0]    tgt_r;
  logic [INC_W-1:0] inc_r;

  // set path
  logic [CUR_W-1:0] mag_r;
  logic             neg_r;
  logic             nz_r;
  logic [TW-1:0]    time_r;
  logic [NUM_W-1:0] prod_r;

  // tick path
  logic             near_r;
  logic [CUR_W-1:0] tq_r;
  logic [CUR_W-1:0] sat_r;

  // result register
  logic                     out_valid_r;
  logic [slr_pkg::CH_W-1:0] out_chan_r;
  logic [slr_pkg::POSQ_W-1:0] out_posq_r;
  logic [PW-1:0]            out_posus_r;
  logic                     out_mov_r;
  logic                     out_ign_r;

  logic in_fire;
  logic in_range;
  logic out_free;

  // memory and divider hookup
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_we;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;

  // combinational working values
  logic [PW-1:0]    aim_c;
  logic [TW-1:0]    time_c;
  logic [CUR_W-1:0] aim_q;
  logic [CUR_W:0]   sdiff;
  logic [PW-1:0]    ttgt_c;
  logic [CUR_W-1:0] tq_c;
  logic [CUR_W:0]   tdist;
  logic [CUR_W:0]   tabs;
  logic [INC_W-1:0] inc_abs;
  logic [INC_W:0]   inc2;
  logic [INC_W:0]   sum;
  logic [CUR_W-1:0] sat_c;
  logic [CUR_W-1:0] qmag;
  logic [INC_W-1:0] inc_new;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_range = {1'b0, in_ch.channel} < (slr_pkg::CH_W + 1)'(CHANNELS);
  assign out_free = !out_valid_r || out_ch.ready;
  assign mem_we   = (state_r == S_DONE) && out_free && !ign_r;

  slr_mem #(
    .DEPTH    (CHANNELS),
    .WIDTH    (ENTRY_W),
    .AW       (AW),
    .RST_WORD (RST_WORD)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (AW'(ch_r)),
    .wdata ({cur_r, tgt_r, inc_r}),
    .re    (in_fire && in_range),
    .raddr (AW'(in_ch.channel)),
    .rdata (mem_rdata)
  );

  slr_div #(
    .NUM_W (NUM_W),
    .DEN_W (TW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVGO),
    .num   (prod_r),
    .den   (time_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    // set: clamp target and time, signed distance to the target
    if (tin_r > P_MAX) begin
      aim_c = P_MAX;
    end else if (tin_r < P_MIN_SET) begin
      aim_c = P_MIN_SET;
    end else begin
      aim_c = tin_r;
    end
    if (dur_r > slr_pkg::DUR_W'(T_MAX)) begin
      time_c = T_MAX;
    end else begin
      time_c = TW'(dur_r);
    end
    aim_q = {aim_c, {FRAC_BITS{1'b0}}};
    sdiff = {1'b0, aim_q} - {1'b0, cur_r};

    // tick: clamp aim, distance against twice the increment
    if (tgt_r > P_MAX) begin
      ttgt_c = P_MAX;
    end else if (tgt_r < P_MIN_TICK) begin
      ttgt_c = P_MIN_TICK;
    end else begin
      ttgt_c = tgt_r;
    end
    tq_c    = {ttgt_c, {FRAC_BITS{1'b0}}};
    tdist   = {1'b0, tq_c} - {1'b0, cur_r};
    tabs    = tdist[CUR_W] ? (~tdist + 1'b1) : tdist;
    inc_abs = inc_r[INC_W-1] ? (~inc_r + 1'b1) : inc_r;
    inc2    = {inc_abs, 1'b0};

    // step with saturation to the pulse width
    sum = {2'b00, cur_r} + {inc_r[INC_W-1], inc_r};
    if (sum[INC_W]) begin
      sat_c = '0;
    end else if (sum[CUR_W]) begin
      sat_c = '1;
    end else begin
      sat_c = sum[CUR_W-1:0];
    end

    // quotient to signed increment, never zero while distance remains
    qmag = div_quo[CUR_W-1:0];
    if (qmag == '0 && nz_r) begin
      qmag = CUR_W'(1);
    end
    inc_new = neg_r ? (~{1'b0, qmag} + 1'b1) : {1'b0, qmag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a result handed over in S_DONE reloads the register in the same cycle
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r  <= in_ch.kind;
            ch_r    <= in_ch.channel;
            tin_r   <= in_ch.target_us;
            dur_r   <= in_ch.duration_ms;
            ign_r   <= !in_range;
            state_r <= in_range ? S_LOAD : S_DONE;
          end
        end
        S_LOAD: begin
          {cur_r, tgt_r, inc_r} <= mem_rdata;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (kind_r == slr_pkg::KIND_SET) begin
            if (tin_r == '0) begin
              // stop where we are
              inc_r   <= '0;
              tgt_r   <= cur_r[CUR_W-1:FRAC_BITS];
              state_r <= S_DONE;
            end else if (time_c < T_TICK) begin
              // too short to ramp, jump
              tgt_r   <= aim_c;
              cur_r   <= aim_q;
              inc_r   <= '0;
              state_r <= S_DONE;
            end else begin
              tgt_r   <= aim_c;
              time_r  <= time_c;
              neg_r   <= sdiff[CUR_W];
              nz_r    <= sdiff != '0;
              mag_r   <= sdiff[CUR_W] ? CUR_W'(~sdiff + 1'b1) : sdiff[CUR_W-1:0];
              state_r <= S_MUL;
            end
          end else if (inc_r == '0) begin
            state_r <= S_DONE;
          end else begin
            near_r  <= {1'b0, tabs} <= inc2;
            tq_r    <= tq_c;
            sat_r   <= sat_c;
            state_r <= S_TSTEP;
          end
        end
        S_MUL: begin
          prod_r  <= NUM_W'(mag_r) * NUM_W'(TICK_MS);
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            inc_r   <= inc_new;
            state_r <= S_DONE;
          end
        end
        S_TSTEP: begin
          if (near_r) begin
            // close enough, snap onto the aim
            cur_r <= tq_r;
            inc_r <= '0;
          end else begin
            cur_r <= sat_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hand over the result once the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_chan_r  <= ch_r;
            out_ign_r   <= ign_r;
            if (ign_r) begin
              out_posq_r  <= '0;
              out_posus_r <= '0;
              out_mov_r   <= 1'b0;
            end else begin
              out_posq_r  <= slr_pkg::POSQ_W'(cur_r);
              out_posus_r <= cur_r[CUR_W-1:FRAC_BITS];
              out_mov_r   <= inc_r != '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.channel_out  = out_chan_r;
  assign out_ch.position_q16 = out_posq_r;
  assign out_ch.position_us  = out_posus_r;
  assign out_ch.moving       = out_mov_r;
  assign out_ch.ignored      = out_ign_r;

endmodule
